// ===== hw/rtl/spe_pkg.sv =====
`default_nettype none
// shared types, constants and codes of the spring pair energy gradient unit
package spe_pkg;

	localparam int COORD_W = 32;
	localparam int LEN_W = 31;
	localparam int ENERGY_W = 63;

	// iterations per stage and stage counts of the iterative units
	localparam int WRAP_STEPS = 2;
	localparam int WRAP_STAGES = COORD_W / WRAP_STEPS;
	localparam int SQRT_STEPS = 3;
	localparam int SQRT_STAGES = 33 / SQRT_STEPS;
	localparam int GRAD_STEPS = 2;
	localparam int GRAD_STAGES = COORD_W / GRAD_STEPS;

	// configuration register indexes
	localparam logic [2:0] REG_PBC_ENABLE = 3'd0;
	localparam logic [2:0] REG_BOX_X = 3'd1;
	localparam logic [2:0] REG_BOX_Y = 3'd2;
	localparam logic [2:0] REG_BOX_Z = 3'd3;
	localparam logic [2:0] REG_BOND_LENGTH = 3'd4;
	localparam logic [2:0] REG_DIAGONAL_LENGTH = 3'd5;

	localparam logic [LEN_W-1:0] BOX_RST = 31'd65536;
	localparam logic [LEN_W-1:0] BOND_RST = 31'd65536;
	localparam logic [LEN_W-1:0] DIAG_RST = 31'd107020;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

	typedef logic [2:0][COORD_W-1:0] coord3_t;

	typedef struct packed {
		logic pbc;
		logic [2:0][LEN_W-1:0] box;
		logic [LEN_W-1:0] bond;
		logic [LEN_W-1:0] diag;
	} cfg_t;

	typedef struct packed {
		logic func;
		logic [2:0] sgn;
		coord3_t ad;
	} wrap_res_t;

	typedef struct packed {
		logic zero;
		logic [2:0] sgn;
		coord3_t ad;
		logic [32:0] r;
		logic [32:0] adiff;
		logic dneg;
	} root_res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/spring_pair_energy_gradient_unit.sv =====
`default_nettype none
// top level of the spring pair energy gradient unit
//
// Streams pairs of Q16.16 points and returns, per pair, the spring energy
// (r - target)^2 in Q32.32 and the gradient 2*d*(r - target)/r on the first
// point, with optional minimum-image wrapping (nearest image, ties to even).
// One transfer is taken every cycle while in_stall is low and every input gives
// exactly one result, in order, after 18 stages of displacement and wrap
// (the remainder by the box is a restoring divider of 2 bits per stage), 15
// stages of squaring, summing and a 3-bit-per-stage square root with
// rounding, and 19 stages of products and a 2-bit-per-stage divider for the
// gradient. All stages advance together; the whole pipe holds only while a
// finished result waits at the output with stall high, and bubbles still move
// forward otherwise. Configuration is taken through a plain write port and
// must be written only while no item is in flight. Status is 1 when the
// wrapped distance is zero (gradient forced to 0, energy target^2) and 2 when
// the energy or a gradient component saturated.
module spring_pair_energy_gradient_unit (
	input wire logic clk,
	input wire logic arst_n,
	// configuration write port
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [30:0] cfg_data,
	// input channel
	input wire logic in_valid,
	output logic in_stall,
	input wire logic func,
	input wire logic [31:0] ax,
	input wire logic [31:0] ay,
	input wire logic [31:0] az,
	input wire logic [31:0] bx,
	input wire logic [31:0] by,
	input wire logic [31:0] bz,
	// result channel
	output logic out_valid,
	input wire logic out_stall,
	output logic [31:0] grad_x,
	output logic [31:0] grad_y,
	output logic [31:0] grad_z,
	output logic [62:0] pair_energy,
	output logic [1:0] status
);

	// configuration registers
	logic pbc_q;
	logic [2:0][30:0] box_q;
	logic [30:0] bond_q;
	logic [30:0] diag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pbc_q <= 1'b0;
			box_q <= {3{spe_pkg::BOX_RST}};
			bond_q <= spe_pkg::BOND_RST;
			diag_q <= spe_pkg::DIAG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				spe_pkg::REG_PBC_ENABLE: pbc_q <= cfg_data[0];
				spe_pkg::REG_BOX_X: box_q[0] <= cfg_data;
				spe_pkg::REG_BOX_Y: box_q[1] <= cfg_data;
				spe_pkg::REG_BOX_Z: box_q[2] <= cfg_data;
				spe_pkg::REG_BOND_LENGTH: bond_q <= cfg_data;
				spe_pkg::REG_DIAGONAL_LENGTH: diag_q <= cfg_data;
				default: ;
			endcase
		end
	end

	spe_pkg::cfg_t cfg;
	assign cfg.pbc = pbc_q;
	assign cfg.box = box_q;
	assign cfg.bond = bond_q;
	assign cfg.diag = diag_q;

	// pipeline advance: everything moves unless the output is held
	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	spe_pkg::coord3_t a_pt;
	spe_pkg::coord3_t b_pt;
	assign a_pt = {az, ay, ax};
	assign b_pt = {bz, by, bx};

	// displacement and wrap
	logic wrap_vld;
	spe_pkg::wrap_res_t wrap_res;

	spe_wrap u_wrap (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cfg(cfg),
		.in_vld(in_valid),
		.in_func(func),
		.a(a_pt),
		.b(b_pt),
		.out_vld(wrap_vld),
		.res(wrap_res)
	);

	// distance and error against the target
	logic root_vld;
	spe_pkg::root_res_t root_res;

	spe_root u_root (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.cfg(cfg),
		.in_vld(wrap_vld),
		.src(wrap_res),
		.out_vld(root_vld),
		.res(root_res)
	);

	// energy and gradient, last stage is the output register
	spe_pkg::coord3_t grad;

	spe_grad u_grad (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_vld(root_vld),
		.src(root_res),
		.out_vld(out_valid),
		.grad(grad),
		.energy(pair_energy),
		.status(status)
	);

	assign grad_x = grad[0];
	assign grad_y = grad[1];
	assign grad_z = grad[2];

	// zero distance always comes with a zeroed gradient
	a_zero_grad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == spe_pkg::ST_ZERO)) |->
		((grad_x == '0) && (grad_y == '0) && (grad_z == '0)))
	else $error("zero distance result with nonzero gradient");

	// the unused status code never appears
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status != 2'd3))
	else $error("undefined status code");

	// a clamped energy is always reported as saturated
	a_energy_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (pair_energy == spe_pkg::ENERGY_MAX)) |->
		(status == spe_pkg::ST_SAT))
	else $error("energy clamped without saturation status");

	// a held result is still valid in the next cycle, with in_stall following out_stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && (in_stall == out_stall)))
	else $error("pipeline moved while the result was held");

endmodule
`default_nettype wire

// ===== hw/rtl/spe_wrap.sv =====
`default_nettype none
// displacement and pipelined minimum-image wrap, three axes in parallel
module spe_wrap (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire spe_pkg::cfg_t cfg,
	input wire logic in_vld,
	input wire logic in_func,
	input wire spe_pkg::coord3_t a,
	input wire spe_pkg::coord3_t b,
	output logic out_vld,
	output spe_pkg::wrap_res_t res
);

	localparam int NST = spe_pkg::WRAP_STAGES;

	typedef struct packed {
		logic [32:0] d;
		logic [31:0] num;
		logic [30:0] rem;
		logic qodd;
	} lane_t;
	typedef lane_t [2:0] lane3_t;

	// one restoring step: remainder of |d| by the box, quotient lsb kept
	function automatic lane_t div_step(lane_t x, logic [30:0] bx);
		logic [31:0] t;
		lane_t y;
		t = {x.rem, x.num[31]};
		y = x;
		y.num = {x.num[30:0], 1'b0};
		if (t >= {1'b0, bx}) begin
			y.rem = 31'(t - {1'b0, bx});
			y.qodd = 1'b1;
		end else begin
			y.rem = t[30:0];
			y.qodd = 1'b0;
		end
		return y;
	endfunction

	function automatic lane3_t div_stage(lane3_t x, logic [2:0][30:0] bx);
		lane3_t y;
		y = x;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < spe_pkg::WRAP_STEPS; j++) begin
				y[k] = div_step(y[k], bx[k]);
			end
		end
		return y;
	endfunction

	logic vld_s1;
	logic func_s1;
	logic [2:0][32:0] d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= in_func;
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= {a[k][31], a[k]} - {b[k][31], b[k]};
			end
		end
	end

	lane3_t init_c;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			init_c[k].d = d_s1[k];
			init_c[k].num = d_s1[k][32] ? 32'(33'd0 - d_s1[k]) : d_s1[k][31:0];
			init_c[k].rem = '0;
			init_c[k].qodd = 1'b0;
		end
	end

	lane3_t lane_sd [NST];
	logic [NST-1:0] vld_sd;
	logic [NST-1:0] func_sd;

	for (genvar i = 0; i < NST; i++) begin : g_div
		lane3_t src;
		logic src_vld;
		logic src_func;
		if (i == 0) begin : g_first
			assign src = init_c;
			assign src_vld = vld_s1;
			assign src_func = func_s1;
		end else begin : g_next
			assign src = lane_sd[i-1];
			assign src_vld = vld_sd[i-1];
			assign src_func = func_sd[i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i] <= 1'b0;
			end else if (adv) begin
				vld_sd[i] <= src_vld;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				lane_sd[i] <= div_stage(src, cfg.box);
				func_sd[i] <= src_func;
			end
		end
	end

	// floor remainder and parity, then round half to even
	logic [2:0] sgn_c;
	spe_pkg::coord3_t ad_c;
	always_comb begin
		lane_t x;
		logic [30:0] bx;
		logic [30:0] remf;
		logic podd;
		logic up;
		logic [31:0] tw;
		logic [32:0] w;
		for (int k = 0; k < 3; k++) begin
			x = lane_sd[NST-1][k];
			bx = cfg.box[k];
			if (!x.d[32]) begin
				remf = x.rem;
				podd = x.qodd;
			end else if (x.rem == '0) begin
				remf = '0;
				podd = x.qodd;
			end else begin
				remf = bx - x.rem;
				podd = !x.qodd;
			end
			tw = {remf, 1'b0};
			up = (tw > {1'b0, bx}) || ((tw == {1'b0, bx}) && podd);
			w = up ? ({2'b00, remf} - {2'b00, bx}) : {2'b00, remf};
			if (!cfg.pbc || (bx == '0)) begin
				w = x.d;
			end
			sgn_c[k] = w[32];
			ad_c[k] = w[32] ? 32'(33'd0 - w) : w[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= vld_sd[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res.func <= func_sd[NST-1];
			res.sgn <= sgn_c;
			res.ad <= ad_c;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/spe_root.sv =====
`default_nettype none
// squared distance, pipelined rounded square root and distance error
module spe_root (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire spe_pkg::cfg_t cfg,
	input wire logic in_vld,
	input wire spe_pkg::wrap_res_t src,
	output logic out_vld,
	output spe_pkg::root_res_t res
);

	localparam int NST = spe_pkg::SQRT_STAGES;

	typedef struct packed {
		logic [32:0] root;
		logic [33:0] rem;
		logic [65:0] n;
	} lane_t;

	typedef struct packed {
		spe_pkg::wrap_res_t w;
		logic zero;
	} meta_t;

	function automatic lane_t sq_step(lane_t x);
		logic [35:0] t;
		logic [35:0] trial;
		lane_t y;
		t = {x.rem, x.n[65:64]};
		trial = {1'b0, x.root, 2'b01};
		y.n = {x.n[63:0], 2'b00};
		if (t >= trial) begin
			y.rem = 34'(t - trial);
			y.root = {x.root[31:0], 1'b1};
		end else begin
			y.rem = t[33:0];
			y.root = {x.root[31:0], 1'b0};
		end
		return y;
	endfunction

	function automatic lane_t sq_stage(lane_t x);
		lane_t y;
		y = x;
		for (int j = 0; j < spe_pkg::SQRT_STEPS; j++) begin
			y = sq_step(y);
		end
		return y;
	endfunction

	// squares
	logic vld_s1;
	spe_pkg::wrap_res_t w_s1;
	logic [2:0][63:0] sq_s1;
	// sum
	logic vld_s2;
	spe_pkg::wrap_res_t w_s2;
	logic [65:0] r2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= src;
			for (int k = 0; k < 3; k++) begin
				sq_s1[k] <= 64'(src.ad[k]) * 64'(src.ad[k]);
			end
			w_s2 <= w_s1;
			r2_s2 <= {2'b00, sq_s1[0]} + {2'b00, sq_s1[1]} + {2'b00, sq_s1[2]};
		end
	end

	lane_t init_c;
	meta_t init_meta_c;
	always_comb begin
		init_c.root = '0;
		init_c.rem = '0;
		init_c.n = r2_s2;
		init_meta_c.w = w_s2;
		init_meta_c.zero = (r2_s2 == '0);
	end

	lane_t lane_sq [NST];
	meta_t meta_sq [NST];
	logic [NST-1:0] vld_sq;

	for (genvar i = 0; i < NST; i++) begin : g_sqrt
		lane_t sl;
		meta_t sm;
		logic sv;
		if (i == 0) begin : g_first
			assign sl = init_c;
			assign sm = init_meta_c;
			assign sv = vld_s2;
		end else begin : g_next
			assign sl = lane_sq[i-1];
			assign sm = meta_sq[i-1];
			assign sv = vld_sq[i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sq[i] <= 1'b0;
			end else if (adv) begin
				vld_sq[i] <= sv;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				lane_sq[i] <= sq_stage(sl);
				meta_sq[i] <= sm;
			end
		end
	end

	// round to nearest: the remainder is r2 - root^2
	logic vld_s3;
	meta_t meta_s3;
	logic [32:0] r_s3;
	lane_t last_c;
	assign last_c = lane_sq[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_sq[NST-1];
			out_vld <= vld_s3;
		end
	end

	logic [30:0] tgt_c;
	logic [33:0] diff_c;
	assign tgt_c = meta_s3.w.func ? cfg.diag : cfg.bond;
	assign diff_c = {1'b0, r_s3} - {3'b000, tgt_c};

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= meta_sq[NST-1];
			r_s3 <= last_c.root + 33'(last_c.rem > {1'b0, last_c.root});
			res.zero <= meta_s3.zero;
			res.sgn <= meta_s3.w.sgn;
			res.ad <= meta_s3.w.ad;
			res.r <= r_s3;
			res.dneg <= diff_c[33];
			res.adiff <= diff_c[33] ? 33'(34'd0 - diff_c) : diff_c[32:0];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/spe_grad.sv =====
`default_nettype none
// energy, pipelined gradient division and saturation
module spe_grad (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic adv,
	input wire logic in_vld,
	input wire spe_pkg::root_res_t src,
	output logic out_vld,
	output spe_pkg::coord3_t grad,
	output logic [62:0] energy,
	output logic [1:0] status
);

	localparam int NST = spe_pkg::GRAD_STAGES;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] num;
		logic [31:0] q;
	} lane_t;
	typedef lane_t [2:0] lane3_t;

	typedef struct packed {
		logic zero;
		logic esat;
		logic [62:0] en;
		logic [33:0] dv;
		logic [2:0] neg;
		logic [2:0] ovf;
	} meta_t;

	function automatic lane_t div_step(lane_t x, logic [33:0] dv);
		logic [34:0] t;
		lane_t y;
		t = {x.rem, x.num[31]};
		y.num = {x.num[30:0], 1'b0};
		if (t >= {1'b0, dv}) begin
			y.rem = 34'(t - {1'b0, dv});
			y.q = {x.q[30:0], 1'b1};
		end else begin
			y.rem = t[33:0];
			y.q = {x.q[30:0], 1'b0};
		end
		return y;
	endfunction

	function automatic lane3_t div_stage(lane3_t x, logic [33:0] dv);
		lane3_t y;
		y = x;
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < spe_pkg::GRAD_STEPS; j++) begin
				y[k] = div_step(y[k], dv);
			end
		end
		return y;
	endfunction

	// products
	logic vld_s1;
	logic zero_s1;
	logic [2:0] neg_s1;
	logic [32:0] r_s1;
	logic [2:0][64:0] p_s1;
	logic [65:0] e_s1;
	// rounding offset added, divisor 2r
	logic vld_s2;
	logic zero_s2;
	logic [2:0] neg_s2;
	logic esat_s2;
	logic [62:0] en_s2;
	logic [33:0] dv_s2;
	logic [2:0][67:0] nn_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1 <= src.zero;
			r_s1 <= src.r;
			for (int k = 0; k < 3; k++) begin
				neg_s1[k] <= src.sgn[k] ^ src.dneg;
				p_s1[k] <= 65'(src.ad[k]) * 65'(src.adiff);
			end
			e_s1 <= 66'(src.adiff) * 66'(src.adiff);
			zero_s2 <= zero_s1;
			neg_s2 <= neg_s1;
			esat_s2 <= (e_s1[65:63] != 3'b000);
			en_s2 <= (e_s1[65:63] != 3'b000) ? spe_pkg::ENERGY_MAX : e_s1[62:0];
			dv_s2 <= {r_s1, 1'b0};
			for (int k = 0; k < 3; k++) begin
				nn_s2[k] <= {1'b0, p_s1[k], 2'b00} + {35'd0, r_s1};
			end
		end
	end

	// high part checked for a quotient of 2^32 or more
	lane3_t init_c;
	meta_t init_meta_c;
	always_comb begin
		init_meta_c.zero = zero_s2;
		init_meta_c.esat = esat_s2;
		init_meta_c.en = en_s2;
		init_meta_c.dv = dv_s2;
		init_meta_c.neg = neg_s2;
		for (int k = 0; k < 3; k++) begin
			init_meta_c.ovf[k] = (nn_s2[k][67:32] >= {2'b00, dv_s2});
			init_c[k].rem = nn_s2[k][65:32];
			init_c[k].num = nn_s2[k][31:0];
			init_c[k].q = '0;
		end
	end

	lane3_t lane_sd [NST];
	meta_t meta_sd [NST];
	logic [NST-1:0] vld_sd;

	for (genvar i = 0; i < NST; i++) begin : g_div
		lane3_t sl;
		meta_t sm;
		logic sv;
		if (i == 0) begin : g_first
			assign sl = init_c;
			assign sm = init_meta_c;
			assign sv = vld_s2;
		end else begin : g_next
			assign sl = lane_sd[i-1];
			assign sm = meta_sd[i-1];
			assign sv = vld_sd[i-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sd[i] <= 1'b0;
			end else if (adv) begin
				vld_sd[i] <= sv;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				lane_sd[i] <= div_stage(sl, sm.dv);
				meta_sd[i] <= sm;
			end
		end
	end

	meta_t fm_c;
	spe_pkg::coord3_t g_c;
	logic [1:0] st_c;
	assign fm_c = meta_sd[NST-1];

	always_comb begin
		logic [31:0] lim;
		logic [31:0] g;
		logic sat;
		logic any_sat;
		any_sat = fm_c.esat;
		for (int k = 0; k < 3; k++) begin
			lim = fm_c.neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			sat = fm_c.ovf[k] || (lane_sd[NST-1][k].q > lim);
			g = sat ? lim : lane_sd[NST-1][k].q;
			any_sat = any_sat || sat;
			g_c[k] = fm_c.neg[k] ? (32'd0 - g) : g;
			if (fm_c.zero) begin
				g_c[k] = '0;
			end
		end
		if (fm_c.zero) begin
			st_c = spe_pkg::ST_ZERO;
		end else if (any_sat) begin
			st_c = spe_pkg::ST_SAT;
		end else begin
			st_c = spe_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= vld_sd[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grad <= g_c;
			energy <= fm_c.en;
			status <= st_c;
		end
	end

endmodule
`default_nettype wire
